[src/wildcard_byte_pattern_scanner_assert.svh]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_assert.svh
// Assertion macros shared by the scanner's checker.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps check failed");

`endif

[src/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Types, codes and helpers shared by the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    // Configuration port geometry.
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    // Pattern storage held by the configuration registers.
    localparam int PAT_BYTES   = 32;
    localparam int PAT_FLAT_W  = PAT_BYTES * 8;

    // Width of an effective pattern length (up to 63).
    localparam int LEN_W       = 7;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0,
        REG_PATTERN_1,
        REG_PATTERN_2,
        REG_PATTERN_3,
        REG_WILDCARD,
        REG_LENGTH
    } cfg_index_t;

    // Outcome codes of a scan.
    typedef enum logic [1:0] {
        STATUS_NONE,
        STATUS_UNIQUE,
        STATUS_AMBIGUOUS,
        STATUS_EMPTY
    } scan_status_t;

    // Length information handed from the configuration block to the matcher.
    typedef struct packed {
        logic             len_zero;
        logic [LEN_W-1:0] len_eff;
        logic [LEN_W-1:0] len_m1;
    } match_ctrl_t;

    // Pattern byte i; bytes past the stored pattern read as zero.
    function automatic logic [7:0] pat_byte(input logic [PAT_FLAT_W-1:0] flat,
                                            input logic [LEN_W-1:0] i);
        logic [7:0] b;
        b = 8'd0;
        if (i < LEN_W'(PAT_BYTES))
        begin
            b = flat[8*i[4:0] +: 8];
        end
        return b;
    endfunction

    // Wildcard flag of pattern byte i; bytes past the stored pattern never are.
    function automatic logic pat_wild(input logic [PAT_BYTES-1:0] mask,
                                      input logic [LEN_W-1:0] i);
        logic w;
        w = 1'b0;
        if (i < LEN_W'(PAT_BYTES))
        begin
            w = mask[i[4:0]];
        end
        return w;
    endfunction

endpackage

[src/wbps_if.sv]
// ----------------------------------------------------------------------------
// wbps_if
// Valid/ready channels of the scanner: incoming bytes and scan results.
// ----------------------------------------------------------------------------

// Channel carrying one image byte per word.
interface wbps_byte_if #(
    parameter int ADDR_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [7:0]           data_byte;
    logic [ADDR_BITS-1:0] byte_address;
    logic                 section_start;
    logic                 scan_end;

    modport source (output valid, data_byte, byte_address, section_start, scan_end,
                    input ready);
    modport sink   (input valid, data_byte, byte_address, section_start, scan_end,
                    output ready);
endinterface

// Channel carrying one scan outcome per word.
interface wbps_result_if #(
    parameter int ADDR_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           scan_status;
    logic [ADDR_BITS-1:0] match_address;

    modport source (output valid, scan_status, match_address, input ready);
    modport sink   (input valid, scan_status, match_address, output ready);
endinterface

[src/wbps_config.sv]
// ----------------------------------------------------------------------------
// wbps_config
// Configuration registers and the pattern aligned to window positions.
// ----------------------------------------------------------------------------
module wbps_config #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [7:0]                        align_byte [PATTERN_MAX],
    output logic [PATTERN_MAX-1:0]            align_care,
    output wbps_pkg::match_ctrl_t             ctrl
);

    logic [wbps_pkg::PAT_FLAT_W-1:0] pat_reg;
    logic [wbps_pkg::PAT_BYTES-1:0]  wild_reg;
    logic [5:0]                      len_reg;

    logic [7:0]                      align_byte_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]          align_care_next;
    wbps_pkg::match_ctrl_t           ctrl_next;
    logic [7:0]                      align_byte_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]          align_care_reg;
    wbps_pkg::match_ctrl_t           ctrl_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            wild_reg <= '0;
            len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (wbps_pkg::cfg_index_t'(cfg_index))
                wbps_pkg::REG_PATTERN_0: pat_reg[0*64 +: 64] <= cfg_data;
                wbps_pkg::REG_PATTERN_1: pat_reg[1*64 +: 64] <= cfg_data;
                wbps_pkg::REG_PATTERN_2: pat_reg[2*64 +: 64] <= cfg_data;
                wbps_pkg::REG_PATTERN_3: pat_reg[3*64 +: 64] <= cfg_data;
                wbps_pkg::REG_WILDCARD:  wild_reg <= cfg_data[wbps_pkg::PAT_BYTES-1:0];
                wbps_pkg::REG_LENGTH:    len_reg  <= cfg_data[5:0];
                default:                 ;
            endcase
        end
    end

    // Window position k must hold pattern byte (length - 1 - k).
    always_comb
    begin
        logic [wbps_pkg::LEN_W-1:0] len_eff;
        logic [wbps_pkg::LEN_W-1:0] idx;
        if (wbps_pkg::LEN_W'(len_reg) > wbps_pkg::LEN_W'(PATTERN_MAX))
        begin
            len_eff = wbps_pkg::LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = wbps_pkg::LEN_W'(len_reg);
        end
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            idx = len_eff - wbps_pkg::LEN_W'(k) - wbps_pkg::LEN_W'(1);
            if (wbps_pkg::LEN_W'(k) < len_eff)
            begin
                align_byte_next[k] = wbps_pkg::pat_byte(pat_reg, idx);
                align_care_next[k] = !wbps_pkg::pat_wild(wild_reg, idx);
            end
            else
            begin
                align_byte_next[k] = 8'd0;
                align_care_next[k] = 1'b0;
            end
        end
        ctrl_next.len_zero = (len_reg == 6'd0);
        ctrl_next.len_eff  = len_eff;
        ctrl_next.len_m1   = len_eff - wbps_pkg::LEN_W'(1);
    end

    // Aligned pattern register, reloaded from the configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                align_byte_reg[k] <= 8'd0;
            end
            align_care_reg <= '0;
            ctrl_reg       <= '{len_zero: 1'b1, default: '0};
        end
        else
        begin
            align_byte_reg <= align_byte_next;
            align_care_reg <= align_care_next;
            ctrl_reg       <= ctrl_next;
        end
    end

    assign align_byte = align_byte_reg;
    assign align_care = align_care_reg;
    assign ctrl       = ctrl_reg;

endmodule

[src/wbps_matcher.sv]
// ----------------------------------------------------------------------------
// wbps_matcher
// Input register, sliding window compare, match counting and result register.
// ----------------------------------------------------------------------------
module wbps_matcher #(
    parameter int PATTERN_MAX = 32,
    parameter int ADDR_BITS   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             align_byte [PATTERN_MAX],
    input  logic [PATTERN_MAX-1:0] align_care,
    input  wbps_pkg::match_ctrl_t  ctrl,
    wbps_byte_if.sink              byte_in,
    wbps_result_if.source          result_out
);

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    // Input register.
    logic                 s1_valid_reg;
    logic [7:0]           s1_byte_reg;
    logic [ADDR_BITS-1:0] s1_addr_reg;
    logic                 s1_start_reg;
    logic                 s1_end_reg;

    // Scan state.
    logic [7:0]           win_reg [PATTERN_MAX];
    logic [7:0]           win_next [PATTERN_MAX];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [1:0]           matches_reg;
    logic [1:0]           matches_next;
    logic [ADDR_BITS-1:0] first_reg;
    logic [ADDR_BITS-1:0] first_next;

    // Result register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           out_status_reg;
    logic [1:0]           out_status_next;
    logic [ADDR_BITS-1:0] out_addr_reg;
    logic [ADDR_BITS-1:0] out_addr_next;

    logic                 advance;
    logic                 hit;
    logic                 accept;

    // The input word moves on unless it closes a scan and the result is stuck.
    assign advance = s1_valid_reg && (!s1_end_reg || !out_valid_reg || result_out.ready);
    assign byte_in.ready = !s1_valid_reg || advance;
    assign accept = byte_in.valid && byte_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            s1_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= byte_in.data_byte;
            s1_addr_reg  <= byte_in.byte_address;
            s1_start_reg <= byte_in.section_start;
            s1_end_reg   <= byte_in.scan_end;
        end
    end

    // Window shift, fill count and per-position compare.
    always_comb
    begin
        logic [CNT_W-1:0] base;
        logic             all_eq;
        win_next[0] = s1_byte_reg;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
        base = s1_start_reg ? '0 : count_reg;
        if (base < CNT_W'(PATTERN_MAX))
        begin
            count_next = base + CNT_W'(1);
        end
        else
        begin
            count_next = base;
        end
        all_eq = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (align_care[k] && (win_next[k] != align_byte[k]))
            begin
                all_eq = 1'b0;
            end
        end
        hit = !ctrl.len_zero && all_eq
              && (wbps_pkg::LEN_W'(count_next) >= ctrl.len_eff);
    end

    // Match count saturating at two, and the start of the first match.
    always_comb
    begin
        matches_next = matches_reg;
        first_next   = first_reg;
        if (hit)
        begin
            if (matches_reg == 2'd0)
            begin
                first_next = s1_addr_reg - ADDR_BITS'(ctrl.len_m1);
            end
            if (matches_reg < 2'd2)
            begin
                matches_next = matches_reg + 2'd1;
            end
        end
    end

    // Outcome of the scan closed by this word.
    always_comb
    begin
        out_addr_next = '0;
        if (ctrl.len_zero)
        begin
            out_status_next = wbps_pkg::STATUS_EMPTY;
        end
        else if (matches_next == 2'd0)
        begin
            out_status_next = wbps_pkg::STATUS_NONE;
        end
        else if (matches_next == 2'd1)
        begin
            out_status_next = wbps_pkg::STATUS_UNIQUE;
            out_addr_next   = first_next;
        end
        else
        begin
            out_status_next = wbps_pkg::STATUS_AMBIGUOUS;
        end
        if (advance && s1_end_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Scan state update; the end of a scan starts the next one clean.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            matches_reg <= 2'd0;
            first_reg   <= '0;
        end
        else if (advance)
        begin
            if (s1_end_reg)
            begin
                count_reg   <= '0;
                matches_reg <= 2'd0;
                first_reg   <= '0;
            end
            else
            begin
                count_reg   <= count_next;
                matches_reg <= matches_next;
                first_reg   <= first_next;
            end
        end
    end

    // Window bytes beyond the fill count never affect a match.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_end_reg)
        begin
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.scan_status   = out_status_reg;
    assign result_out.match_address = out_addr_reg;

endmodule

[src/wildcard_byte_pattern_scanner.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams image bytes past a masked pattern and reports one outcome per scan.
// ----------------------------------------------------------------------------
// Bytes arrive on byte_in, one word per byte, with address, section start and
// scan end flags. Outcomes leave on result_out, one word for each byte that
// carries scan_end: status none, unique (with start address), ambiguous or
// empty pattern. The pattern, wildcard mask and length are written through
// cfg_we/cfg_index/cfg_data only while the block is idle, a rule for the user
// that the block does not enforce; they take effect through the aligned
// pattern register. A byte is accepted every cycle unless a closing byte
// waits on a stalled result; a closing byte moves from the input register
// through the window compare to the result register. The depth of the
// compare is set by the window width, one byte comparator per position
// feeding an AND tree. While result_out stalls, bytes that close no scan flow;
// a closing byte waits in the input register until the result is taken.
// Reset clears the pattern (length zero), the window fill count and the
// match count; no result is pending after reset.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
    parameter int PATTERN_MAX = 32,
    parameter int ADDR_BITS   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    wbps_byte_if.sink                         byte_in,
    wbps_result_if.source                     result_out
);

    logic [7:0]             align_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] align_care;
    wbps_pkg::match_ctrl_t  ctrl;

    // Configuration registers and aligned pattern.
    wbps_config #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_config (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .align_byte (align_byte),
        .align_care (align_care),
        .ctrl       (ctrl)
    );

    // Window compare and result path.
    wbps_matcher #(
        .PATTERN_MAX (PATTERN_MAX),
        .ADDR_BITS   (ADDR_BITS)
    ) u_matcher (
        .clk        (clk),
        .rst_n      (rst_n),
        .align_byte (align_byte),
        .align_care (align_care),
        .ctrl       (ctrl),
        .byte_in    (byte_in),
        .result_out (result_out)
    );

endmodule

[src/wbps_checker.sv]
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks on the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scanner_assert.svh"

module wbps_checker #(
    parameter int ADDR_BITS = 32
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 in_end,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           out_status,
    input logic [ADDR_BITS-1:0] out_addr
);

    // A stalled result holds its word.
    `WBPS_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
        out_valid && $stable(out_status) && $stable(out_addr))

    // Only a unique match carries an address.
    `WBPS_ASSERT_NOW(a_addr_zero, out_valid && (out_status != wbps_pkg::STATUS_UNIQUE),
        out_addr == '0)

    // With no result pending the block always takes a byte.
    `WBPS_ASSERT_NOW(a_ready_free, !out_valid, in_ready)

    // A new result is raised from a closing byte held in the input register,
    // so the check looks back past that register to the byte's acceptance.
    `WBPS_ASSERT_NOW(a_result_cause, $rose(out_valid),
        $past(in_valid && in_ready && in_end, 2))

endmodule

bind wildcard_byte_pattern_scanner wbps_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .in_end     (byte_in.scan_end),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_status (result_out.scan_status),
    .out_addr   (result_out.match_address)
);
